@@ rtl/hkot_pkg.sv @@
package hkot_pkg;

  localparam int unsigned TableDepthDefault = 256;
  localparam logic [63:0] HashStart = 64'd5381;
  localparam logic [17:0] HashModulus = 18'd246822;
  localparam int unsigned HashShift = 5;

  localparam logic KindInsert = 1'b0;
  localparam logic KindLookup = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [6:0] key_byte;
    logic       last;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  position;
    logic [31:0] occurrences;
    logic [17:0] key_hash;
    logic        status;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic hash_step;   // fold byte into running hash
    logic mod_start;   // load hash into reducer
    logic mod_step;    // one accumulate, fold or subtract step
    logic srch_init;   // begin linear search
    logic srch_step;   // compare next entry
    logic shift_init;  // begin insertion shift
    logic shift_step;  // move one entry up
    logic finish;      // write entry / update count, form response
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic mod_done;
    logic srch_done;
    logic shift_done;
  } sts_t;

endpackage

@@ rtl/hkot_datapath.sv @@
module hkot_datapath import hkot_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  ctl_t ctl,
  output sts_t sts,
  output logic rsp_valid,
  output rsp_t rsp
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(TABLE_DEPTH);
  // 2^18, 2^36 and 2^54 reduced by the modulus
  localparam logic [17:0] Fold1 = 18'((64'd1 << 18) % 64'(HashModulus));
  localparam logic [17:0] Fold2 = 18'((64'(Fold1) * 64'(Fold1)) % 64'(HashModulus));
  localparam logic [17:0] Fold3 = 18'((64'(Fold2) * 64'(Fold1)) % 64'(HashModulus));
  localparam int unsigned ChunkSteps = 4;
  localparam int unsigned FoldSteps = 6;
  localparam int unsigned ModSteps = ChunkSteps + FoldSteps + 1;

  logic [17:0] key_mem [TABLE_DEPTH];
  logic [31:0] cnt_mem [TABLE_DEPTH];

  logic [63:0] hash;
  logic [63:0] hash_fold;
  logic [63:0] quo;      // hash snapshot, consumed 18 bits per accumulate step
  logic [39:0] acc;
  logic [3:0]  mod_cnt;
  logic [17:0] chunk_mult;
  logic [35:0] chunk_prod;
  logic [39:0] fold_val;
  logic        kind;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] idx;
  logic        hit;
  logic [17:0] rd_key;
  logic [31:0] rd_cnt;
  logic        rd_ok;
  logic [17:0] key;
  logic [CW-1:0] sh;     // shift pointer, counts down from entry_count
  logic        sh_done;
  logic        sh_ok;
  logic [17:0] sh_key;
  logic [31:0] sh_cnt;
  logic        need_shift;
  logic        shift_go;
  logic        bump;
  rsp_t        rsp_next;

  assign hash_fold = (hash << HashShift) + hash + 64'(req.key_byte);

  // reduce 18-bit chunks by their weights, fold the high part down, then
  // one compare and subtract
  always_comb begin
    case (mod_cnt[1:0])
      2'd0: chunk_mult = 18'd1;
      2'd1: chunk_mult = Fold1;
      2'd2: chunk_mult = Fold2;
      default: chunk_mult = Fold3;
    endcase
  end
  assign chunk_prod = 36'(quo[17:0]) * 36'(chunk_mult);
  assign fold_val = 40'(acc[39:18]) * 40'(Fold1) + 40'(acc[17:0]);
  assign key = acc[17:0];

  assign hit = (idx < entry_count) && (rd_key == key);
  assign need_shift = !hit && kind == KindInsert && entry_count < Full;
  assign bump = kind == KindInsert && rd_cnt != '1;
  assign sh_done = (sh == idx);
  assign shift_go = ctl.shift_step && need_shift && !sh_done;

  assign sts.mod_done = (mod_cnt == 4'(ModSteps));
  // search finishes when at end or an entry >= key seen
  assign sts.srch_done = rd_ok && (idx >= entry_count || rd_key >= key);
  assign sts.shift_done = sh_done || !need_shift;

  always_comb begin
    rsp_next = '0;
    rsp_next.key_hash = key;
    if (hit) begin
      rsp_next.found = 1'b1;
      rsp_next.position = 8'(idx);
      rsp_next.occurrences = bump ? rd_cnt + 32'd1 : rd_cnt;
    end else if (kind == KindInsert) begin
      if (entry_count >= Full) begin
        rsp_next.status = 1'b1;
      end else begin
        rsp_next.position = 8'(idx);
        rsp_next.occurrences = 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= HashStart;
    end else if (ctl.mod_start) begin
      hash <= HashStart;
    end else if (ctl.hash_step) begin
      hash <= hash_fold;
    end
    if (ctl.hash_step) begin
      kind <= req.kind;
    end
    if (ctl.mod_start) begin
      quo <= hash_fold;
      acc <= '0;
      mod_cnt <= '0;
    end else if (ctl.mod_step) begin
      mod_cnt <= mod_cnt + 4'd1;
      if (mod_cnt < 4'(ChunkSteps)) begin
        quo <= quo >> 18;
        acc <= acc + 40'(chunk_prod);
      end else if (mod_cnt < 4'(ChunkSteps + FoldSteps)) begin
        acc <= fold_val;
      end else if (acc >= 40'(HashModulus)) begin
        acc <= acc - 40'(HashModulus);
      end
    end
    if (ctl.srch_init) begin
      idx <= '0;
      rd_ok <= 1'b0;
    end else if (ctl.srch_step) begin
      if (!rd_ok) begin
        rd_key <= key_mem[idx[AW-1:0]];
        rd_cnt <= cnt_mem[idx[AW-1:0]];
        rd_ok <= 1'b1;
      end else if (!(idx >= entry_count || rd_key >= key)) begin
        idx <= idx + CW'(1);
        rd_ok <= 1'b0;
      end
    end
    // read the entry below, then write it one slot up
    if (ctl.shift_init) begin
      sh <= entry_count;
      sh_ok <= 1'b0;
    end else if (shift_go) begin
      if (!sh_ok) begin
        sh_key <= key_mem[AW'(sh - CW'(1))];
        sh_cnt <= cnt_mem[AW'(sh - CW'(1))];
        sh_ok <= 1'b1;
      end else begin
        sh <= sh - CW'(1);
        sh_ok <= 1'b0;
      end
    end
    if (shift_go && sh_ok) begin
      key_mem[sh[AW-1:0]] <= sh_key;
      cnt_mem[sh[AW-1:0]] <= sh_cnt;
    end else if (ctl.finish && hit && bump) begin
      cnt_mem[idx[AW-1:0]] <= rd_cnt + 32'd1;
    end else if (ctl.finish && need_shift) begin
      key_mem[idx[AW-1:0]] <= key;
      cnt_mem[idx[AW-1:0]] <= 32'd1;
    end
    if (ctl.finish) begin
      rsp <= rsp_next;
    end
    if (rst) begin
      entry_count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= ctl.finish;
      if (ctl.finish && need_shift) entry_count <= entry_count + CW'(1);
    end
  end

endmodule

@@ rtl/hkot_ctrl.sv @@
module hkot_ctrl import hkot_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  typedef enum logic [4:0] {
    IDLE  = 5'b00001,
    MOD   = 5'b00010,
    SRCH  = 5'b00100,
    SHIFT = 5'b01000,
    FIN   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (start) begin
          ctl.hash_step = 1'b1;
          if (req.last) state_next = MOD;
        end
      end
      MOD: begin
        // reducer was loaded with the folded hash; step until it reports done
        if (sts.mod_done) begin
          ctl.srch_init = 1'b1;
          state_next = SRCH;
        end else begin
          ctl.mod_step = 1'b1;
        end
      end
      SRCH: begin
        ctl.srch_step = 1'b1;
        if (sts.srch_done) begin
          ctl.shift_init = 1'b1;
          state_next = SHIFT;
        end
      end
      SHIFT: begin
        ctl.shift_step = 1'b1;
        if (sts.shift_done) state_next = FIN;
      end
      FIN: begin
        ctl.finish = 1'b1;
        state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
    ctl.mod_start = (state == IDLE) && start && req.last;
  end

  assign busy = (state != IDLE);

endmodule

@@ rtl/hashed_key_occurrence_table.sv @@
// channel  | ports                        | handshake
// request  | start, req (req_t)           | taken when start && !busy
// result   | done, rsp (rsp_t)            | one-cycle strobe on done
// A non-last byte leaves busy low. A last byte keeps busy high through
// the fold-and-subtract reduction mod 246822, a linear search past p
// entries, shifting s entries up on an insert of a new key, and a
// finish state.
// done pulses in the first cycle with busy low again.
// rst is synchronous; it empties the table and restarts the hash.
// The receiver cannot stall; done pulses once per last byte.
module hashed_key_occurrence_table import hkot_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  ctl_t ctl;
  sts_t sts;
  req_t req_q;

  // mod_start and hash fold happen on the same edge; datapath sees live byte
  hkot_ctrl u_ctrl (
    .clk, .rst, .start, .req, .sts, .ctl, .busy
  );

  hkot_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk, .rst, .req(req_q), .ctl, .sts, .rsp_valid(done), .rsp
  );

  assign req_q = req;

endmodule

@@ rtl/hkot_checker.sv @@
module hkot_checker import hkot_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input req_t req,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.last |=> busy) else $error("no busy after last byte");
  a_mid_free: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !req.last |=> !busy) else $error("busy after mid byte");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than a cycle");
  a_hash_rng: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.key_hash < HashModulus) else $error("hash out of range");
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status |-> !rsp.found && rsp.occurrences == 32'd0)
    else $error("bad full response");

endmodule

bind hashed_key_occurrence_table hkot_checker u_chk (.*);
